// ===== rtl/i2c_master_transfer_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - assertion macros
// Shared property shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2c_mts_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - package
// Sizes, codes, and the structs passed between the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mts_pkg;

   // Transmit buffer depth and derived widths
   localparam int BUF_DEPTH = 16;
   localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int POS_W     = $clog2(BUF_DEPTH + 1);
   localparam int CMP_W     = (POS_W > 5) ? POS_W : 5;

   // Request kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // Bus engine status codes (low three bits masked)
   localparam logic [7:0] ST_MASK      = 8'hF8;
   localparam logic [7:0] ST_BUS_ERR   = 8'h00;
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_REP_START = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_SLAR_NACK = 8'h48;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;
   localparam logic [7:0] ST_NO_INFO   = 8'hF8;
   localparam logic [7:0] ST_NONE      = 8'hFF;

   // Result status codes
   localparam logic [2:0] RES_BUSY     = 3'd0;
   localparam logic [2:0] RES_IDLE     = 3'd1;
   localparam logic [2:0] RES_NACK_ARB = 3'd2;
   localparam logic [2:0] RES_BUS_ERR  = 3'd3;
   localparam logic [2:0] RES_REJECT   = 3'd4;

   // Reported mode codes
   localparam logic [2:0] MODE_CODE_READY = 3'd0;
   localparam logic [2:0] MODE_CODE_INIT  = 3'd1;
   localparam logic [2:0] MODE_CODE_REP   = 3'd2;
   localparam logic [2:0] MODE_CODE_MT    = 3'd3;
   localparam logic [2:0] MODE_CODE_MR    = 3'd4;

   // Engine commands
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_TX    = 3'd3,
      CMD_ACK   = 3'd4,
      CMD_NACK  = 3'd5
   } cmd_type;

   // Sequencer mode, one-hot
   typedef enum logic [4:0] {
      MODE_READY = 5'b00001,
      MODE_INIT  = 5'b00010,
      MODE_REP   = 5'b00100,
      MODE_MT    = 5'b01000,
      MODE_MR    = 5'b10000
   } mode_type;

   // One request item
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] tx_slot;
      logic [7:0] data_byte;
      logic [4:0] tx_count;
      logic [4:0] rx_count;
      logic       keep_bus;
      logic [7:0] bus_status;
   } item_type;

   // Sequencer state
   typedef struct packed {
      mode_type         mode;
      logic [POS_W-1:0] tx_pos;
      logic [POS_W-1:0] tx_total;
      logic [POS_W-1:0] rx_pos;
      logic [POS_W-1:0] rx_total;
      logic             hold_bus;
      logic [7:0]       status;
   } seq_state_type;

   // Transmit buffer write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } buf_wr_type;

   // One result item
   typedef struct packed {
      cmd_type    command;
      logic [7:0] tx_data;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_position;
      logic [2:0] mode_now;
      logic [2:0] result_status;
      logic [7:0] error_code;
   } result_type;

   // Mode to reported code
   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_INIT: c = MODE_CODE_INIT;
         MODE_REP:  c = MODE_CODE_REP;
         MODE_MT:   c = MODE_CODE_MT;
         MODE_MR:   c = MODE_CODE_MR;
         default:   c = MODE_CODE_READY;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - top level
// Each request (buffer load, transfer start or bus status event) passes
// through an input register, a single pass of decision logic that updates
// the sequencer state, and a result register holding the engine command.
// Exactly one result leaves for every request. The block takes one request
// per clock while the result channel does not stall: a request waits in the
// input register and moves to the result register once that is free or
// being drained, so throughput is one request per cycle, limited only by
// the state update loop through the decision logic. A stalled result holds
// while the input register keeps the next request. No clearing pass after
// reset; the transmit buffer must be loaded before the bytes a transfer sends.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tx_slot[3:0], data_byte[11:4], tx_count[16:12], rx_count[21:17],
   // keep_bus[22], bus_status[30:23], zero[31]
   input  wire logic [31:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // command[2:0], tx_data[10:3], rx_byte[18:11], rx_position[22:19],
   // mode_now[25:23], result_status[28:26], error_code[36:29], zero[39:37]
   output logic [39:0]      rsp_tdata,
   // rx_valid[0]
   output logic [0:0]       rsp_tuser
);

   i2c_mts_pkg::item_type      item_ff;
   logic                       in_valid_ff, in_valid_in;
   i2c_mts_pkg::seq_state_type state_ff, state_in;
   i2c_mts_pkg::result_type    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   i2c_mts_pkg::buf_wr_type    buf_wr;
   i2c_mts_pkg::buf_wr_type    buf_wr_raw;
   logic [7:0]                 rd_data, first_data;
   logic                       advance;
   logic                       req_take;

   // Handshake: advance when the result register is free or being drained
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_take     = req_tvalid && req_tready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         item_ff.kind       <= req_tuser;
         item_ff.tx_slot    <= req_tdata[3:0];
         item_ff.data_byte  <= req_tdata[11:4];
         item_ff.tx_count   <= req_tdata[16:12];
         item_ff.rx_count   <= req_tdata[21:17];
         item_ff.keep_bus   <= req_tdata[22];
         item_ff.bus_status <= req_tdata[30:23];
      end
   end

   // Transmit buffer
   i2c_mts_txbuf u_txbuf (
      .clock      (clock),
      .wr         (buf_wr),
      .rd_addr    (state_ff.tx_pos[i2c_mts_pkg::IDX_W-1:0]),
      .rd_data    (rd_data),
      .first_data (first_data)
   );

   // Decision logic
   i2c_mts_step u_step (
      .item       (item_ff),
      .cur        (state_ff),
      .rd_data    (rd_data),
      .first_data (first_data),
      .nxt        (state_in),
      .wr         (buf_wr_raw),
      .res        (res_in)
   );

   // Buffer write only on a request that is processed
   always_comb begin
      buf_wr    = buf_wr_raw;
      buf_wr.en = buf_wr_raw.en && advance;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode     <= i2c_mts_pkg::MODE_READY;
         state_ff.tx_pos   <= '0;
         state_ff.tx_total <= '0;
         state_ff.rx_pos   <= '0;
         state_ff.rx_total <= '0;
         state_ff.hold_bus <= 1'b0;
         state_ff.status   <= i2c_mts_pkg::ST_NONE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // Result channel packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_ff.rx_valid;
   assign rsp_tdata  = {3'b000, res_ff.error_code, res_ff.result_status, res_ff.mode_now,
                        res_ff.rx_position, res_ff.rx_byte, res_ff.tx_data,
                        res_ff.command};

endmodule

`default_nettype wire

// ===== rtl/i2c_mts_txbuf.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - transmit buffer
// Register file for the bytes to send; one write port, a read port at the
// current transmit index and a fixed read of the first (address) byte.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mts_txbuf (
   input  wire logic                        clock,
   input  wire i2c_mts_pkg::buf_wr_type     wr,
   input  wire logic [i2c_mts_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]                       rd_data,
   output logic [7:0]                       first_data
);

   logic [7:0] store_ff [i2c_mts_pkg::BUF_DEPTH];

   // Write port, no reset: the user must see that entries are loaded before use; nothing here enforces it
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // Read ports
   assign rd_data    = store_ff[rd_addr];
   assign first_data = store_ff[0];

endmodule

`default_nettype wire

// ===== rtl/i2c_mts_step.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - step logic
// Combinational decision for one request: next state, buffer write and the
// engine command with its status fields.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mts_step (
   input  wire i2c_mts_pkg::item_type      item,
   input  wire i2c_mts_pkg::seq_state_type cur,
   input  wire logic [7:0]                 rd_data,
   input  wire logic [7:0]                 first_data,
   output i2c_mts_pkg::seq_state_type      nxt,
   output i2c_mts_pkg::buf_wr_type         wr,
   output i2c_mts_pkg::result_type         res
);

   localparam int PW = i2c_mts_pkg::POS_W;
   localparam int CW = i2c_mts_pkg::CMP_W;

   logic [7:0]    st;
   logic          rejected;
   logic          room;
   logic [PW-1:0] rx_after;

   assign st = item.bus_status & i2c_mts_pkg::ST_MASK;

   // Receive index with the incoming byte counted, if there is room for it
   assign room     = (cur.rx_pos < PW'(i2c_mts_pkg::BUF_DEPTH));
   assign rx_after = room ? (cur.rx_pos + PW'(1)) : cur.rx_pos;

   always_comb begin
      nxt         = cur;
      wr          = '0;
      res         = '0;
      res.command = i2c_mts_pkg::CMD_NONE;
      rejected    = 1'b0;

      case (item.kind)
         // Buffer load, ignored beyond the buffer
         i2c_mts_pkg::KIND_LOAD: begin
            if (CW'(item.tx_slot) < CW'(i2c_mts_pkg::BUF_DEPTH)) begin
               wr.en   = 1'b1;
               wr.addr = i2c_mts_pkg::IDX_W'(item.tx_slot);
               wr.data = item.data_byte;
            end
         end

         // Transfer start
         i2c_mts_pkg::KIND_START: begin
            if ((cur.mode != i2c_mts_pkg::MODE_READY && cur.mode != i2c_mts_pkg::MODE_REP)
                || CW'(item.tx_count) > CW'(i2c_mts_pkg::BUF_DEPTH)) begin
               rejected = 1'b1;
            end else begin
               nxt.tx_pos   = '0;
               nxt.tx_total = PW'(item.tx_count);
               nxt.rx_pos   = '0;
               nxt.rx_total = (CW'(item.rx_count) > CW'(i2c_mts_pkg::BUF_DEPTH)) ?
                              PW'(i2c_mts_pkg::BUF_DEPTH) : PW'(item.rx_count);
               nxt.hold_bus = item.keep_bus;
               if (cur.mode == i2c_mts_pkg::MODE_REP) begin
                  // bus already held: send the address byte straight away
                  res.tx_data = first_data;
                  nxt.tx_pos  = PW'(1);
                  res.command = i2c_mts_pkg::CMD_TX;
               end else begin
                  res.command = i2c_mts_pkg::CMD_START;
               end
               nxt.mode = i2c_mts_pkg::MODE_INIT;
            end
         end

         // Bus status event
         i2c_mts_pkg::KIND_EVENT: begin
            case (st)
               i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_SLAW_ACK,
               i2c_mts_pkg::ST_DATA_ACK: begin
                  if (st == i2c_mts_pkg::ST_SLAW_ACK) begin
                     nxt.mode = i2c_mts_pkg::MODE_MT;
                  end
                  if (cur.tx_pos < cur.tx_total) begin
                     res.tx_data = rd_data;
                     nxt.tx_pos  = cur.tx_pos + PW'(1);
                     nxt.status  = i2c_mts_pkg::ST_NO_INFO;
                     res.command = i2c_mts_pkg::CMD_TX;
                  end else if (cur.hold_bus) begin
                     nxt.status  = i2c_mts_pkg::ST_NO_INFO;
                     res.command = i2c_mts_pkg::CMD_START;
                  end else begin
                     nxt.mode    = i2c_mts_pkg::MODE_READY;
                     nxt.status  = i2c_mts_pkg::ST_NONE;
                     res.command = i2c_mts_pkg::CMD_STOP;
                  end
               end

               i2c_mts_pkg::ST_SLAR_ACK: begin
                  nxt.mode    = i2c_mts_pkg::MODE_MR;
                  nxt.status  = i2c_mts_pkg::ST_NO_INFO;
                  res.command = ((PW+1)'(cur.rx_pos) + (PW+1)'(1) < (PW+1)'(cur.rx_total)) ?
                                i2c_mts_pkg::CMD_ACK : i2c_mts_pkg::CMD_NACK;
               end

               i2c_mts_pkg::ST_RX_ACK: begin
                  res.rx_valid    = room;
                  res.rx_byte     = room ? item.data_byte : 8'h00;
                  res.rx_position = room ? 4'(cur.rx_pos) : 4'h0;
                  nxt.rx_pos      = rx_after;
                  nxt.status      = i2c_mts_pkg::ST_NO_INFO;
                  res.command     = ((PW+1)'(rx_after) + (PW+1)'(1) < (PW+1)'(cur.rx_total)) ?
                                    i2c_mts_pkg::CMD_ACK : i2c_mts_pkg::CMD_NACK;
               end

               i2c_mts_pkg::ST_RX_NACK: begin
                  res.rx_valid    = room;
                  res.rx_byte     = room ? item.data_byte : 8'h00;
                  res.rx_position = room ? 4'(cur.rx_pos) : 4'h0;
                  nxt.rx_pos      = rx_after;
                  nxt.status      = i2c_mts_pkg::ST_NONE;
                  if (cur.hold_bus) begin
                     res.command = i2c_mts_pkg::CMD_START;
                  end else begin
                     nxt.mode    = i2c_mts_pkg::MODE_READY;
                     res.command = i2c_mts_pkg::CMD_STOP;
                  end
               end

               // NACK or lost arbitration
               i2c_mts_pkg::ST_SLAR_NACK, i2c_mts_pkg::ST_SLAW_NACK,
               i2c_mts_pkg::ST_DATA_NACK, i2c_mts_pkg::ST_ARB_LOST: begin
                  if (cur.hold_bus) begin
                     nxt.status  = st;
                     res.command = i2c_mts_pkg::CMD_START;
                  end else begin
                     nxt.mode    = i2c_mts_pkg::MODE_READY;
                     nxt.status  = i2c_mts_pkg::ST_NONE;
                     res.command = i2c_mts_pkg::CMD_STOP;
                  end
               end

               i2c_mts_pkg::ST_REP_START: begin
                  nxt.mode = i2c_mts_pkg::MODE_REP;
               end

               i2c_mts_pkg::ST_BUS_ERR: begin
                  nxt.status  = i2c_mts_pkg::ST_BUS_ERR;
                  nxt.mode    = i2c_mts_pkg::MODE_READY;
                  res.command = i2c_mts_pkg::CMD_STOP;
               end

               default: begin
               end
            endcase
         end

         default: begin
         end
      endcase

      // Mode and status after the request
      res.mode_now = i2c_mts_pkg::mode_code(nxt.mode);
      if (rejected) begin
         res.result_status = i2c_mts_pkg::RES_REJECT;
         res.error_code    = 8'hFF;
      end else if (nxt.status == i2c_mts_pkg::ST_NO_INFO) begin
         res.result_status = i2c_mts_pkg::RES_BUSY;
         res.error_code    = 8'hFF;
      end else if (nxt.status == i2c_mts_pkg::ST_NONE) begin
         res.result_status = i2c_mts_pkg::RES_IDLE;
         res.error_code    = 8'hFF;
      end else begin
         res.result_status = (nxt.status == i2c_mts_pkg::ST_BUS_ERR) ?
                             i2c_mts_pkg::RES_BUS_ERR : i2c_mts_pkg::RES_NACK_ARB;
         res.error_code    = nxt.status;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/i2c_mts_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - port checker
// Watches the top level's ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_mts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   logic       req_seen;
   logic [2:0] command;
   logic [2:0] res_status;
   logic [7:0] err_code;

   assign req_seen   = req_tvalid && req_tready;
   assign command    = rsp_tdata[2:0];
   assign res_status = rsp_tdata[28:26];
   assign err_code   = rsp_tdata[36:29];

   // A stalled result keeps its payload
   `MTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // A received byte comes only with an ack, nack, start or stop command
   `MTS_ASSERT_NOW(a_rx_cmd, clock, reset, rsp_tvalid && rsp_tuser[0],
      command == i2c_mts_pkg::CMD_ACK || command == i2c_mts_pkg::CMD_NACK ||
      command == i2c_mts_pkg::CMD_START || command == i2c_mts_pkg::CMD_STOP,
      "received byte with wrong command")

   // A rejected start issues nothing
   `MTS_ASSERT_NOW(a_reject, clock, reset,
      rsp_tvalid && res_status == i2c_mts_pkg::RES_REJECT,
      command == i2c_mts_pkg::CMD_NONE && err_code == 8'hFF && !rsp_tuser[0],
      "rejected request issued a command")

   // An error code is shown only with an error status
   `MTS_ASSERT_NOW(a_err_code, clock, reset, rsp_tvalid && err_code != 8'hFF,
      res_status == i2c_mts_pkg::RES_NACK_ARB || res_status == i2c_mts_pkg::RES_BUS_ERR,
      "error code without error status")

   // A request taken is followed, past the input register, by a result on offer
   `MTS_ASSERT_NEXT(a_req_flow, clock, reset, req_seen, ##1 rsp_tvalid, "request lost")

endmodule

bind i2c_master_transfer_sequencer i2c_mts_checker u_i2c_mts_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - self-checking testbench
// Drives buffer loads, transfer starts and bus status events into the
// request channel and checks every result against a cycle-free predictor
// of the sequencer or a hand-typed expectation. A short table of hand-picked
// requests comes first, then randomised transfers (write, read, repeated
// start, faults) mixed with noise, with random idle gaps on both channels.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int ITEM_TARGET    = 1250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;

   // one row of stimulus, optionally with a hand-typed expected result
   typedef struct {
      i2c_mts_pkg::item_type   req;
      bit                      typed;
      i2c_mts_pkg::result_type want;
      bit                      drain_first;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // predictor state
   logic [2:0]  seq_mode;
   logic [7:0]  tx_bytes [i2c_mts_pkg::BUF_DEPTH];
   logic [4:0]  tx_next;
   logic [4:0]  tx_len;
   logic [4:0]  rx_next;
   logic [4:0]  rx_len;
   logic        hold_line;
   logic [7:0]  bus_state;

   i2c_mts_pkg::result_type pending_results [$];
   stim_row_type            run_rows [$];
   bit          drain_next;
   int          counted_items;
   int          mismatch_count;
   int          requests_sent;
   int          results_checked;
   int          bytes_received;
   int          starts_taken;
   int          rejections;
   int          dropped_bytes;
   int          src_calm;
   int          sink_calm;
   int          sink_wait;
   int          stall_count;

   i2c_master_transfer_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // request builders; fields the kind does not use are randomised
   function automatic i2c_mts_pkg::item_type base_item(logic [1:0] kind);
      i2c_mts_pkg::item_type it;
      it.kind       = kind;
      it.tx_slot    = 4'($urandom_range(0, 15));
      it.data_byte  = 8'($urandom_range(0, 255));
      it.tx_count   = 5'($urandom_range(0, 16));
      it.rx_count   = 5'($urandom_range(0, 16));
      it.keep_bus   = 1'($urandom_range(0, 1));
      it.bus_status = 8'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic i2c_mts_pkg::item_type load_item(logic [3:0] slot, logic [7:0] value);
      i2c_mts_pkg::item_type it;
      it           = base_item(i2c_mts_pkg::KIND_LOAD);
      it.tx_slot   = slot;
      it.data_byte = value;
      return it;
   endfunction

   function automatic i2c_mts_pkg::item_type start_item(logic [4:0] ntx, logic [4:0] nrx,
                                                        logic keep);
      i2c_mts_pkg::item_type it;
      it          = base_item(i2c_mts_pkg::KIND_START);
      it.tx_count = ntx;
      it.rx_count = nrx;
      it.keep_bus = keep;
      return it;
   endfunction

   function automatic i2c_mts_pkg::item_type event_item(logic [7:0] status, logic [7:0] value);
      i2c_mts_pkg::item_type it;
      it            = base_item(i2c_mts_pkg::KIND_EVENT);
      it.bus_status = status;
      it.data_byte  = value;
      return it;
   endfunction

   function automatic i2c_mts_pkg::result_type res(i2c_mts_pkg::cmd_type cmd,
                                                   logic [2:0] mode, logic [2:0] stat,
                                                   logic [7:0] err);
      i2c_mts_pkg::result_type r;
      r               = '0;
      r.command       = cmd;
      r.mode_now      = mode;
      r.result_status = stat;
      r.error_code    = err;
      return r;
   endfunction

   // predictor: applies one request to the shadow state, returns the result
   function automatic i2c_mts_pkg::result_type next_engine_result(
      i2c_mts_pkg::item_type it);
      i2c_mts_pkg::result_type r;
      logic [7:0] st;
      bit         rejected;
      bit         rx_event;
      r         = '0;
      r.command = i2c_mts_pkg::CMD_NONE;
      rejected  = 1'b0;
      rx_event  = 1'b0;
      st        = it.bus_status & i2c_mts_pkg::ST_MASK;
      case (it.kind)
         i2c_mts_pkg::KIND_LOAD: begin
            tx_bytes[it.tx_slot] = it.data_byte;
         end
         i2c_mts_pkg::KIND_START: begin
            if ((seq_mode != i2c_mts_pkg::MODE_CODE_READY &&
                 seq_mode != i2c_mts_pkg::MODE_CODE_REP) ||
                it.tx_count > i2c_mts_pkg::BUF_DEPTH) begin
               rejected = 1'b1;
            end else begin
               tx_next   = '0;
               tx_len    = it.tx_count;
               rx_next   = '0;
               rx_len    = (it.rx_count > i2c_mts_pkg::BUF_DEPTH) ?
                           5'(i2c_mts_pkg::BUF_DEPTH) : it.rx_count;
               hold_line = it.keep_bus;
               // repeated start already on the bus: address byte goes straight out
               if (seq_mode == i2c_mts_pkg::MODE_CODE_REP) begin
                  r.tx_data = tx_bytes[0];
                  tx_next   = 5'd1;
                  r.command = i2c_mts_pkg::CMD_TX;
               end else begin
                  r.command = i2c_mts_pkg::CMD_START;
               end
               seq_mode = i2c_mts_pkg::MODE_CODE_INIT;
            end
         end
         i2c_mts_pkg::KIND_EVENT: begin
            case (st)
               i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_SLAW_ACK,
               i2c_mts_pkg::ST_DATA_ACK: begin
                  if (st == i2c_mts_pkg::ST_SLAW_ACK) seq_mode = i2c_mts_pkg::MODE_CODE_MT;
                  if (tx_next < tx_len) begin
                     r.tx_data = tx_bytes[tx_next[3:0]];
                     tx_next   = tx_next + 5'd1;
                     bus_state = i2c_mts_pkg::ST_NO_INFO;
                     r.command = i2c_mts_pkg::CMD_TX;
                  end else if (hold_line) begin
                     bus_state = i2c_mts_pkg::ST_NO_INFO;
                     r.command = i2c_mts_pkg::CMD_START;
                  end else begin
                     seq_mode  = i2c_mts_pkg::MODE_CODE_READY;
                     bus_state = i2c_mts_pkg::ST_NONE;
                     r.command = i2c_mts_pkg::CMD_STOP;
                  end
               end
               i2c_mts_pkg::ST_SLAR_ACK: begin
                  seq_mode = i2c_mts_pkg::MODE_CODE_MR;
               end
               i2c_mts_pkg::ST_RX_ACK, i2c_mts_pkg::ST_RX_NACK: begin
                  rx_event = 1'b1;
               end
               i2c_mts_pkg::ST_SLAW_NACK, i2c_mts_pkg::ST_DATA_NACK,
               i2c_mts_pkg::ST_ARB_LOST, i2c_mts_pkg::ST_SLAR_NACK: begin
                  if (hold_line) begin
                     bus_state = st;
                     r.command = i2c_mts_pkg::CMD_START;
                  end else begin
                     seq_mode  = i2c_mts_pkg::MODE_CODE_READY;
                     bus_state = i2c_mts_pkg::ST_NONE;
                     r.command = i2c_mts_pkg::CMD_STOP;
                  end
               end
               i2c_mts_pkg::ST_REP_START: begin
                  seq_mode = i2c_mts_pkg::MODE_CODE_REP;
               end
               i2c_mts_pkg::ST_BUS_ERR: begin
                  bus_state = i2c_mts_pkg::ST_BUS_ERR;
                  seq_mode  = i2c_mts_pkg::MODE_CODE_READY;
                  r.command = i2c_mts_pkg::CMD_STOP;
               end
               default: ;
            endcase
            // received byte, dropped once the index has saturated
            if (rx_event) begin
               if (rx_next < i2c_mts_pkg::BUF_DEPTH) begin
                  r.rx_valid    = 1'b1;
                  r.rx_byte     = it.data_byte;
                  r.rx_position = rx_next[3:0];
                  rx_next       = rx_next + 5'd1;
               end else begin
                  dropped_bytes++;
               end
            end
            // ack/nack choice for the next byte to be read
            if (st == i2c_mts_pkg::ST_SLAR_ACK || st == i2c_mts_pkg::ST_RX_ACK) begin
               bus_state = i2c_mts_pkg::ST_NO_INFO;
               r.command = (int'(rx_next) + 1 < int'(rx_len)) ?
                           i2c_mts_pkg::CMD_ACK : i2c_mts_pkg::CMD_NACK;
            end else if (st == i2c_mts_pkg::ST_RX_NACK) begin
               bus_state = i2c_mts_pkg::ST_NONE;
               if (hold_line) begin
                  r.command = i2c_mts_pkg::CMD_START;
               end else begin
                  seq_mode  = i2c_mts_pkg::MODE_CODE_READY;
                  r.command = i2c_mts_pkg::CMD_STOP;
               end
            end
         end
         default: ;
      endcase

      r.mode_now = seq_mode;
      if (rejected) begin
         r.result_status = i2c_mts_pkg::RES_REJECT;
         r.error_code    = i2c_mts_pkg::ST_NONE;
      end else if (bus_state == i2c_mts_pkg::ST_NO_INFO) begin
         r.result_status = i2c_mts_pkg::RES_BUSY;
         r.error_code    = i2c_mts_pkg::ST_NONE;
      end else if (bus_state == i2c_mts_pkg::ST_NONE) begin
         r.result_status = i2c_mts_pkg::RES_IDLE;
         r.error_code    = i2c_mts_pkg::ST_NONE;
      end else begin
         r.result_status = (bus_state == i2c_mts_pkg::ST_BUS_ERR) ?
                           i2c_mts_pkg::RES_BUS_ERR : i2c_mts_pkg::RES_NACK_ARB;
         r.error_code    = bus_state;
      end
      return r;
   endfunction

   // queue a request; ignored status events are not counted
   task automatic push_row(i2c_mts_pkg::item_type it, bit typed = 1'b0,
                           i2c_mts_pkg::result_type want = '0);
      stim_row_type row;
      row.req         = it;
      row.typed       = typed;
      row.want        = want;
      row.drain_first = drain_next;
      drain_next      = 1'b0;
      if (!(it.kind == i2c_mts_pkg::KIND_EVENT &&
            (it.bus_status & i2c_mts_pkg::ST_MASK) > i2c_mts_pkg::ST_RX_NACK))
         counted_items++;
      run_rows.push_back(row);
   endtask

   // one well-formed transfer with random content, sometimes cut by a fault
   task automatic add_transfer();
      int         ntx;
      int         nrx;
      int         r;
      int         k;
      int         i;
      bit         rd;
      bit         keep;
      logic [7:0] codes [$];
      ntx = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) ntx = $urandom_range(17, 31);
      r   = $urandom_range(0, 19);
      nrx = (r < 12) ? $urandom_range(0, 4) :
            (r < 17) ? $urandom_range(5, 16) : $urandom_range(16, 31);
      keep = ($urandom_range(0, 3) == 0);
      rd   = $urandom_range(0, 1);
      if ($urandom_range(0, 1) == 1) begin
         for (i = 0; i < ntx && i < i2c_mts_pkg::BUF_DEPTH; i++)
            push_row(load_item(4'(i), 8'($urandom_range(0, 255))));
      end
      push_row(start_item(5'(ntx), 5'(nrx), keep));
      codes.push_back(i2c_mts_pkg::ST_START);
      if (rd) begin
         codes.push_back(i2c_mts_pkg::ST_SLAR_ACK);
         k = (nrx > i2c_mts_pkg::BUF_DEPTH) ? i2c_mts_pkg::BUF_DEPTH : nrx;
         for (i = 1; i < k; i++) codes.push_back(i2c_mts_pkg::ST_RX_ACK);
         // overrun the receive index on full-length reads
         if (k >= i2c_mts_pkg::BUF_DEPTH)
            repeat ($urandom_range(0, 2)) codes.push_back(i2c_mts_pkg::ST_RX_ACK);
         codes.push_back(i2c_mts_pkg::ST_RX_NACK);
      end else begin
         codes.push_back(i2c_mts_pkg::ST_SLAW_ACK);
         for (i = 1; i < ntx; i++) codes.push_back(i2c_mts_pkg::ST_DATA_ACK);
      end
      if ($urandom_range(0, 5) == 0) begin
         k = $urandom_range(1, codes.size());
         while (codes.size() > k) codes.delete(codes.size() - 1);
         case ($urandom_range(0, 4))
            0:       codes.push_back(i2c_mts_pkg::ST_SLAW_NACK);
            1:       codes.push_back(i2c_mts_pkg::ST_DATA_NACK);
            2:       codes.push_back(i2c_mts_pkg::ST_ARB_LOST);
            3:       codes.push_back(i2c_mts_pkg::ST_SLAR_NACK);
            default: codes.push_back(i2c_mts_pkg::ST_BUS_ERR);
         endcase
      end
      if (keep && $urandom_range(0, 9) != 0) codes.push_back(i2c_mts_pkg::ST_REP_START);
      foreach (codes[j])
         push_row(event_item(codes[j] | 8'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
   endtask

   // stray requests: any kind, known or unknown status codes
   task automatic add_noise();
      i2c_mts_pkg::item_type it;
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 2))
            0: it = load_item(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            1: it = start_item(5'($urandom_range(0, 20)), 5'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)));
            default: begin
               it = base_item(i2c_mts_pkg::KIND_EVENT);
               if ($urandom_range(0, 1) == 1)
                  it.bus_status = {5'($urandom_range(0, 11)), 3'($urandom_range(0, 7))};
            end
         endcase
         push_row(it);
      end
   endtask

   task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                  results_checked, what, got_v, want_v);
   endtask

   // result channel: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      i2c_mts_pkg::result_type got;
      i2c_mts_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.command       = i2c_mts_pkg::cmd_type'(rsp_tdata[2:0]);
         got.tx_data       = rsp_tdata[10:3];
         got.rx_byte       = rsp_tdata[18:11];
         got.rx_position   = rsp_tdata[22:19];
         got.mode_now      = rsp_tdata[25:23];
         got.result_status = rsp_tdata[28:26];
         got.error_code    = rsp_tdata[36:29];
         got.rx_valid      = rsp_tuser[0];
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, command", got.command, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.command !== want.command)
               report_mismatch("command", got.command, want.command);
            if (got.tx_data !== want.tx_data)
               report_mismatch("tx_data", got.tx_data, want.tx_data);
            if (got.rx_valid !== want.rx_valid)
               report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
            if (got.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
            if (got.rx_position !== want.rx_position)
               report_mismatch("rx_position", got.rx_position, want.rx_position);
            if (got.mode_now !== want.mode_now)
               report_mismatch("mode_now", got.mode_now, want.mode_now);
            if (got.result_status !== want.result_status)
               report_mismatch("result_status", got.result_status, want.result_status);
            if (got.error_code !== want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
         end
         results_checked++;
         if (got.rx_valid === 1'b1) bytes_received++;
         if (got.result_status === i2c_mts_pkg::RES_REJECT) rejections++;
      end
   end

   // result back-pressure: random stalls with calm stretches
   always @(negedge clock) begin
      if (sink_calm > 0) begin
         sink_calm--;
         sink_wait = 0;
      end
      if (sink_wait > 0) begin
         rsp_tready <= 1'b0;
         sink_wait--;
      end else begin
         rsp_tready <= 1'b1;
         if (sink_calm == 0) begin
            sink_wait = pick_gap();
            if ($urandom_range(0, 199) == 0) sink_calm = $urandom_range(50, 150);
         end
      end
   end

   // watchdog: cycles in which neither channel moves anything
   initial begin
      stall_count = 0;
      while (stall_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_count = 0;
         else
            stall_count++;
      end
      $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // stimulus, request driver and end of run
   initial begin
      int i;
      int gap;
      i2c_mts_pkg::result_type predicted;
      seq_mode  = i2c_mts_pkg::MODE_CODE_READY;
      tx_next   = '0;
      tx_len    = '0;
      rx_next   = '0;
      rx_len    = '0;
      hold_line = 1'b0;
      bus_state = i2c_mts_pkg::ST_NONE;
      for (i = 0; i < i2c_mts_pkg::BUF_DEPTH; i++) tx_bytes[i] = '0;
      drain_next = 1'b0;

      // directed part: idle status, loads, write, NACK with hold, repeated
      // start with no bytes, short read, busy and oversized starts, bus error
      push_row(event_item(i2c_mts_pkg::ST_NONE, 8'h00), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(load_item(4'd0, 8'hA5), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(load_item(4'd15, 8'hFF), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(load_item(4'd1, 8'h00), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(load_item(4'd2, 8'h3C), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(start_item(5'd3, 5'd0, 1'b0), 1'b1,
               res(i2c_mts_pkg::CMD_START, i2c_mts_pkg::MODE_CODE_INIT,
                   i2c_mts_pkg::RES_IDLE, i2c_mts_pkg::ST_NONE));
      push_row(start_item(5'd3, 5'd0, 1'b0), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_INIT,
                   i2c_mts_pkg::RES_REJECT, i2c_mts_pkg::ST_NONE));
      push_row(event_item(i2c_mts_pkg::ST_START, 8'h11));
      push_row(event_item(i2c_mts_pkg::ST_SLAW_ACK, 8'h22));
      push_row(event_item(i2c_mts_pkg::ST_DATA_ACK, 8'h33));
      push_row(event_item(i2c_mts_pkg::ST_DATA_ACK, 8'h44));
      push_row(start_item(5'd1, 5'd31, 1'b1));
      push_row(event_item(i2c_mts_pkg::ST_START | 8'h07, 8'h55));
      push_row(event_item(i2c_mts_pkg::ST_SLAW_NACK, 8'h66));
      push_row(event_item(i2c_mts_pkg::ST_REP_START, 8'h77));
      push_row(start_item(5'd0, 5'd2, 1'b0));
      push_row(event_item(i2c_mts_pkg::ST_SLAR_ACK, 8'h88));
      push_row(event_item(i2c_mts_pkg::ST_RX_ACK, 8'hFF));
      push_row(event_item(i2c_mts_pkg::ST_RX_NACK, 8'h00));
      push_row(start_item(5'd17, 5'd0, 1'b0), 1'b1,
               res(i2c_mts_pkg::CMD_NONE, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_REJECT, i2c_mts_pkg::ST_NONE));
      push_row(start_item(5'd16, 5'd16, 1'b1));
      push_row(event_item(i2c_mts_pkg::ST_BUS_ERR, 8'h99), 1'b1,
               res(i2c_mts_pkg::CMD_STOP, i2c_mts_pkg::MODE_CODE_READY,
                   i2c_mts_pkg::RES_BUS_ERR, i2c_mts_pkg::ST_BUS_ERR));
      push_row(event_item(i2c_mts_pkg::ST_ARB_LOST, 8'hAA));
      push_row(event_item(i2c_mts_pkg::ST_SLAR_NACK | 8'h07, 8'hBB));
      push_row(event_item(i2c_mts_pkg::ST_DATA_NACK, 8'hCC));

      // random part: whole buffer written first, after a full drain
      drain_next = 1'b1;
      for (i = 0; i < i2c_mts_pkg::BUF_DEPTH; i++)
         push_row(load_item(4'(i), 8'($urandom_range(0, 255))));
      while (counted_items < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 85) add_transfer();
         else add_noise();
         if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      end

      // reset, synchronous, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      src_calm = 0;
      foreach (run_rows[n]) begin
         if (run_rows[n].drain_first) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (src_calm > 0) begin
            src_calm--;
            gap = 0;
         end else begin
            gap = pick_gap();
            if ($urandom_range(0, 59) == 0) src_calm = $urandom_range(20, 60);
         end
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tdata  <= {1'b0, run_rows[n].req.bus_status, run_rows[n].req.keep_bus,
                        run_rows[n].req.rx_count, run_rows[n].req.tx_count,
                        run_rows[n].req.data_byte, run_rows[n].req.tx_slot};
         req_tuser  <= run_rows[n].req.kind;
         do @(posedge clock); while (req_tready !== 1'b1);
         // request taken at this edge
         requests_sent++;
         if (run_rows[n].req.kind == i2c_mts_pkg::KIND_START) starts_taken++;
         predicted = next_engine_result(run_rows[n].req);
         pending_results.push_back(run_rows[n].typed ? run_rows[n].want : predicted);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 0);

      $display("run covered %0d requests (%0d transfer starts, %0d rejected), %0d results",
               requests_sent, starts_taken, rejections, results_checked);
      $display("received bytes reported %0d, bytes dropped at a full index %0d, mismatches %0d",
               bytes_received, dropped_bytes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
